// ===== rtl/core/smbr_pkg.sv =====
// shared types and constants of the sliding minimum baseline restorer
package smbr_pkg;

  // configuration register indexes
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 7;

  localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_INFINITE_MODE = 1'd1;

  localparam logic [CFG_DATA_BITS-1:0] WINDOW_LENGTH_RST = 7'd16;

  // control broadcast from the top level to every cell of the row
  typedef struct packed {
    logic shift_en;  // a sample is accepted this cycle
    logic restart;   // that sample opens a new record
  } smbr_ctl_t;

endpackage

// ===== rtl/core/smbr_cell.sv =====
// one cell of the suffix minimum row
module smbr_cell
  import smbr_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smbr_ctl_t                     ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] prev_min,
  input  logic                          tap_sel,
  output logic signed [SAMPLE_BITS-1:0] cell_min,
  output logic        [SAMPLE_BITS-1:0] tap_out
);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic signed [SAMPLE_BITS-1:0] min_r;
  logic signed [SAMPLE_BITS-1:0] min_nxt;

  // a new record sees only the current sample
  always_comb begin
    if (ctl.restart || (sample < prev_min)) begin
      min_nxt = sample;
    end else begin
      min_nxt = prev_min;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= SAMPLE_MAXV;
    end else if (ctl.shift_en) begin
      min_r <= min_nxt;
    end
  end

  assign cell_min = min_r;
  assign tap_out  = tap_sel ? min_r : '0;

endmodule

// ===== rtl/core/sliding_min_baseline_restore.sv =====
// top level of the sliding minimum baseline restorer
//
// baseline restoration of a sampled detector record
// - in_* stream: one signed sample per transaction in in_tdata, in_tuser
//   flags the first sample of a record
// - out_* stream: one restored value per input transaction, same order
// - cfg_* port: register 0 window_length (saturates at MAX_WINDOW),
//   register 1 infinite_mode; write only while no transaction is in flight
// windowed mode: sample minus the minimum of the sample and up to
// window_length earlier samples of the record
// infinite mode: sample minus the running minimum of the record, first
// sample passes unchanged
// latency: the result is registered, out_tvalid rises one cycle after
// the input transaction
// throughput: one sample per cycle, set by the single-cycle update of the
// row of MAX_WINDOW suffix minimum cells
// reset: all cells and the running minimum go to the most positive code,
// window_length to 16, infinite_mode to 0, output empty
// stall: a full output register with out_tready low drops in_tready, so
// nothing moves until the result is taken
module sliding_min_baseline_restore
  import smbr_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16,
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W       = SAMPLE_BITS + 1,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [IN_TDATA_W-1:0]        in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                         in_tuser,   // [0] record_start
  // output stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata,  // [SAMPLE_BITS:0] restored
  // configuration write port
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_BITS-1:0]     cfg_addr,
  input  logic [CFG_DATA_BITS-1:0]     cfg_wdata
);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  // one-hot tap of the cell that holds the window minimum; all zero for
  // a window of zero
  function automatic logic [MAX_WINDOW-1:0] tap_decode(input logic [CFG_DATA_BITS-1:0] w);
    logic [MAX_WINDOW-1:0] sel;
    sel = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      sel[k] = (32'(w) == k + 1) || ((k == MAX_WINDOW - 1) && (32'(w) > MAX_WINDOW));
    end
    return sel;
  endfunction

  // configuration
  logic [MAX_WINDOW-1:0] tap_sel_r;
  logic                  infinite_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_sel_r       <= tap_decode(WINDOW_LENGTH_RST);
      infinite_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WINDOW_LENGTH: tap_sel_r       <= tap_decode(cfg_wdata);
        REG_INFINITE_MODE: infinite_mode_r <= cfg_wdata[0];
        default:           ;
      endcase
    end
  end

  // input handshake: a free or draining output register takes a new sample
  logic                          out_valid_r;
  logic                          in_accept;
  logic signed [SAMPLE_BITS-1:0] sample;
  smbr_ctl_t                     ctl;

  assign in_tready   = !out_valid_r || out_tready;
  assign in_accept   = in_tvalid && in_tready;
  assign sample      = $signed(in_tdata[SAMPLE_BITS-1:0]);
  assign ctl.shift_en = in_accept;
  assign ctl.restart  = in_tuser;

  // row of suffix minimum cells: cell k holds the minimum of up to k+1 most
  // recent earlier samples of the record
  logic signed [SAMPLE_BITS-1:0] cell_min [MAX_WINDOW];
  logic        [SAMPLE_BITS-1:0] tap_out  [MAX_WINDOW];

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] prev_min;
    if (k == 0) begin : g_head
      assign prev_min = SAMPLE_MAXV;
    end else begin : g_link
      assign prev_min = cell_min[k-1];
    end

    smbr_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sample   (sample),
      .prev_min (prev_min),
      .tap_sel  (tap_sel_r[k]),
      .cell_min (cell_min[k]),
      .tap_out  (tap_out[k])
    );
  end

  // gather the selected cell
  logic [SAMPLE_BITS-1:0] tap_val;
  always_comb begin
    tap_val = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      tap_val = tap_val | tap_out[k];
    end
  end

  // windowed baseline; a new record has no earlier samples
  logic signed [SAMPLE_BITS-1:0] base;
  always_comb begin
    if (!in_tuser && (|tap_sel_r) && ($signed(tap_val) < sample)) begin
      base = $signed(tap_val);
    end else begin
      base = sample;
    end
  end

  // running minimum since the record start
  logic signed [SAMPLE_BITS-1:0] running_min_r;
  logic signed [SAMPLE_BITS-1:0] running_min_nxt;

  always_comb begin
    if (in_tuser || (sample < running_min_r)) begin
      running_min_nxt = sample;
    end else begin
      running_min_nxt = running_min_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_min_r <= SAMPLE_MAXV;
    end else if (in_accept) begin
      running_min_r <= running_min_nxt;
    end
  end

  // result
  logic signed [OUT_W-1:0] restored_nxt;
  logic signed [OUT_W-1:0] restored_r;

  always_comb begin
    if (infinite_mode_r) begin
      if (in_tuser) begin
        restored_nxt = OUT_W'(sample);
      end else begin
        restored_nxt = OUT_W'(sample) - OUT_W'(running_min_nxt);
      end
    end else begin
      restored_nxt = OUT_W'(sample) - OUT_W'(base);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      restored_r <= restored_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({{(OUT_TDATA_W-OUT_W){1'b0}}, restored_r});

  // checks

  // the windowed baseline never exceeds the sample
  a_window_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !infinite_mode_r |=> !out_tdata[SAMPLE_BITS])
    else $error("windowed result is negative");

  // the first sample of a record restores to zero in windowed mode
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tuser && !infinite_mode_r |=> out_tdata[OUT_W-1:0] == '0)
    else $error("record start did not restore to zero");

  // the head cell holds the last accepted sample
  a_head_cell: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> cell_min[0] == $past(sample))
    else $error("head cell lost the accepted sample");

  // the tail cell of the suffix minimum row never exceeds the head cell
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    cell_min[MAX_WINDOW-1] <= cell_min[0])
    else $error("suffix minimum row out of order");

endmodule
